[rtl/b64e_pkg.sv]
// Package for the base64 encoder with a permuted alphabet.
// Holds the alphabet table, the padding character and the shared widths.
// No dependencies.
package b64e_pkg;

	localparam int unsigned ByteW  = 8;
	localparam int unsigned IdxW   = 6;
	localparam int unsigned Chars  = 4;

	localparam logic [ByteW-1:0] PAD_CHAR = 8'h23;

	// Permuted alphabet, indexed by the 6-bit group value
	localparam logic [ByteW-1:0] ALPHABET [0:63] = '{
		"p", "A", "0", "B", "a", "C", "D", "E", "F", "G", "H", "L", "M", "N",
		"O", "4", "P", "Q", "R", "T", "U", "V", "W", "X", "Y", "Z",
		"b", "c", "9", "d", "e", "f", "I", "g", "h", "J", "i", "j", "l", "K",
		"m", "n", "o", "q", "r", "s", "t", "u", "v", "w", "x", "y",
		"z", "1", "2", "k", "3", "5", "S", "6", "7", "8", "-", "_"
	};

	// Count of bytes held in the current group
	typedef logic [1:0] grp_cnt_t;

	// Position of the character in the output group
	typedef logic [1:0] char_pos_t;

endpackage

[rtl/base64_custom_alphabet_encoder_core.sv]
// Base64 encoder core with a permuted 64-character alphabet and '#' padding.
// The first character follows in the cycle after the item that closes its group.
// Throughput: one byte per cycle while a group gathers; four characters per group,
// one per cycle while tready is high, set by the single four-entry character buffer.
// Reset (arst_n, asynchronous, active low) empties the buffer and the pending group.
// Depends on b64e_pkg.
module base64_custom_alphabet_encoder_core (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_axis_tvalid,
	output logic       s_axis_tready,
	input  logic [7:0] s_axis_tdata,  // [7:0] data_byte
	input  logic       s_axis_tlast,  // end_of_message
	output logic       m_axis_tvalid,
	input  logic       m_axis_tready,
	output logic [7:0] m_axis_tdata,  // [7:0] out_char
	output logic       m_axis_tlast   // last_char
);

	logic [b64e_pkg::ByteW-1:0] pend0_q;
	logic [b64e_pkg::ByteW-1:0] pend1_q;
	b64e_pkg::grp_cnt_t         grp_cnt_q;

	logic [b64e_pkg::ByteW-1:0] chars_q [b64e_pkg::Chars];
	logic                       eom_q;
	logic                       busy_q;
	b64e_pkg::char_pos_t        pos_q;

	logic                       store_only;
	logic                       buf_free;
	logic                       s_acc;
	logic                       m_acc;
	logic                       close_grp;
	logic [b64e_pkg::ByteW-1:0] b0;
	logic [b64e_pkg::ByteW-1:0] b1;
	logic [b64e_pkg::ByteW-1:0] b2;
	logic [b64e_pkg::IdxW-1:0]  idx [b64e_pkg::Chars];
	logic [b64e_pkg::ByteW-1:0] new_chars [b64e_pkg::Chars];
	logic [2:0]                 n_chars;

	// Handshake: a byte that only joins the group is always taken
	assign store_only    = (grp_cnt_q != 2'd2) && !s_axis_tlast;
	assign m_acc         = m_axis_tvalid && m_axis_tready;
	assign buf_free      = !busy_q || (m_acc && (pos_q == 2'd3));
	assign s_axis_tready = store_only || buf_free;
	assign s_acc         = s_axis_tvalid && s_axis_tready;
	assign close_grp     = s_acc && !store_only;

	// Select the group bytes, zero-filling a short final group
	always_comb begin
		unique case (grp_cnt_q)
			2'd0: begin
				b0 = s_axis_tdata;
				b1 = '0;
				b2 = '0;
				n_chars = 3'd2;
			end
			2'd1: begin
				b0 = pend0_q;
				b1 = s_axis_tdata;
				b2 = '0;
				n_chars = 3'd3;
			end
			default: begin
				b0 = pend0_q;
				b1 = pend1_q;
				b2 = s_axis_tdata;
				n_chars = 3'd4;
			end
		endcase
	end

	// Split into 6-bit indexes and look up characters, padding the tail
	always_comb begin
		idx[0] = b0[7:2];
		idx[1] = {b0[1:0], b1[7:4]};
		idx[2] = {b1[3:0], b2[7:6]};
		idx[3] = b2[5:0];
		for (int k = 0; k < b64e_pkg::Chars; k++) begin
			if (3'(k) < n_chars) begin
				new_chars[k] = b64e_pkg::ALPHABET[idx[k]];
			end else begin
				new_chars[k] = b64e_pkg::PAD_CHAR;
			end
		end
	end

	// Gather bytes of the current group
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend0_q   <= '0;
			pend1_q   <= '0;
			grp_cnt_q <= '0;
		end else if (s_acc) begin
			if (store_only) begin
				if (grp_cnt_q == 2'd0) begin
					pend0_q <= s_axis_tdata;
				end else begin
					pend1_q <= s_axis_tdata;
				end
				grp_cnt_q <= grp_cnt_q + 2'd1;
			end else begin
				pend0_q   <= '0;
				pend1_q   <= '0;
				grp_cnt_q <= '0;
			end
		end
	end

	// Load a finished group into the buffer and advance through it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			pos_q  <= '0;
			eom_q  <= 1'b0;
			for (int k = 0; k < b64e_pkg::Chars; k++) begin
				chars_q[k] <= '0;
			end
		end else if (close_grp) begin
			busy_q <= 1'b1;
			pos_q  <= '0;
			eom_q  <= s_axis_tlast;
			for (int k = 0; k < b64e_pkg::Chars; k++) begin
				chars_q[k] <= new_chars[k];
			end
		end else if (m_acc) begin
			pos_q <= pos_q + 2'd1;
			if (pos_q == 2'd3) begin
				busy_q <= 1'b0;
			end
		end
	end

	assign m_axis_tvalid = busy_q;
	assign m_axis_tdata  = chars_q[pos_q];
	assign m_axis_tlast  = eom_q && (pos_q == 2'd3);

	// A group never holds three pending bytes
	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		grp_cnt_q != 2'd3)
		else $error("group count reached three");

	// A closed group shows its first character in the next cycle
	a_grp_start: assert property (@(posedge clk) disable iff (!arst_n)
		close_grp |=> (m_axis_tvalid && (pos_q == 2'd0)))
		else $error("closed group not presented");

	// A byte that only joins the group leaves the buffer untouched
	a_store_keeps_buf: assert property (@(posedge clk) disable iff (!arst_n)
		(s_acc && store_only && !m_acc) |=> ($stable(busy_q) && $stable(pos_q)))
		else $error("buffer disturbed by stored byte");

	// A group is only closed when the buffer has room for it
	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		close_grp |-> (!busy_q || (m_acc && (pos_q == 2'd3))))
		else $error("buffer overrun");

endmodule
